// ----- rtl/mbps_pkg.sv -----
// Package for the masked byte pattern search block.
// Holds sizes, the register map and the configuration bundle type.
// No dependencies.
`default_nettype none

package mbps_pkg;

    localparam int PATTERN_MAX   = 32;
    localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
    localparam int PAT_REGS      = 4;
    localparam int PAT_REG_BYTES = PAT_REGS * 8;
    localparam int CARE_W        = 32;
    localparam int PLEN_W        = 6;
    localparam int CNT_W         = 32;
    localparam int ADDR_W        = 64;
    localparam int APB_DW        = 64;
    localparam int REG_IDX_W     = 3;
    localparam int APB_AW        = REG_IDX_W + 3;

    typedef logic [7:0] t_byte;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PAT0 = 3'd0,
        REG_PAT1 = 3'd1,
        REG_PAT2 = 3'd2,
        REG_PAT3 = 3'd3,
        REG_CARE = 3'd4,
        REG_LEN  = 3'd5,
        REG_BASE = 3'd6
    } t_reg_idx;

    // pattern aligned to the window: entry p is compared with window entry p
    typedef struct packed {
        t_byte [PATTERN_MAX-1:0] pat;
        logic [PATTERN_MAX-1:0]  care;
        logic [LEN_W-1:0]        len;
        logic [ADDR_W-1:0]       base;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/mbps_if.sv -----
// Request and result channel interfaces of the pattern search block.
// Valid/ready handshake with payload. No dependencies.
`default_nettype none

interface mbps_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       region_end;

    modport source (output valid, data_byte, region_end, input ready);
    modport sink   (input valid, data_byte, region_end, output ready);
endinterface

interface mbps_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] match_address;

    modport source (output valid, found, match_address, input ready);
    modport sink   (input valid, found, match_address, output ready);
endinterface

`default_nettype wire

// ----- rtl/mbps_cfg.sv -----
// Configuration registers with APB-style access, plus the window-aligned
// pattern and care mask derived from them. Depends on mbps_pkg.
`default_nettype none

module mbps_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mbps_pkg::APB_AW-1:0] paddr,
    input  wire logic [mbps_pkg::APB_DW-1:0] pwdata,
    output logic      [mbps_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output mbps_pkg::t_cfg                   o_cfg
);
    import mbps_pkg::*;

    logic [63:0]            r_pat [PAT_REGS];
    logic [CARE_W-1:0]      r_care;
    logic [PLEN_W-1:0]      r_len;
    logic [ADDR_W-1:0]      r_base;
    t_cfg                   r_cfg;
    t_cfg                   n_cfg;
    t_reg_idx               reg_idx;
    logic                   wr_en;
    t_byte [PAT_REG_BYTES-1:0] pat_all;
    logic [LEN_W-1:0]       eff_len;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:3]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign pat_all = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};
    assign eff_len = (32'(r_len) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX) : LEN_W'(r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PAT_REGS; k++) begin
                r_pat[k] <= '0;
            end
            r_care <= '0;
            r_len  <= '0;
            r_base <= '0;
        end else if (wr_en) begin
            unique case (reg_idx) inside
                REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: begin
                    r_pat[paddr[4:3]] <= pwdata;
                end
                REG_CARE: r_care <= pwdata[CARE_W-1:0];
                REG_LEN:  r_len  <= pwdata[PLEN_W-1:0];
                REG_BASE: r_base <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx) inside
            REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: prdata = r_pat[paddr[4:3]];
            REG_CARE: prdata = {{(APB_DW-CARE_W){1'b0}}, r_care};
            REG_LEN:  prdata = {{(APB_DW-PLEN_W){1'b0}}, r_len};
            REG_BASE: prdata = r_base;
            default:  prdata = '0;
        endcase
    end

    // pattern byte (len-1-p) lines up with window entry p (entry 0 newest)
    always_comb begin
        logic [LEN_W-1:0] idx;
        n_cfg      = '0;
        n_cfg.len  = eff_len;
        n_cfg.base = r_base;
        for (int p = 0; p < PATTERN_MAX; p++) begin
            idx = eff_len - LEN_W'(p) - LEN_W'(1);
            if (LEN_W'(p) < eff_len && 32'(idx) < PAT_REG_BYTES) begin
                n_cfg.pat[p]  = pat_all[5'(idx)];
                n_cfg.care[p] = r_care[5'(idx)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/mbps_core.sv -----
// Search datapath: request register, byte window, masked compare, counters
// and result register. Depends on mbps_pkg and the channel interfaces.
`default_nettype none

module mbps_core (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  mbps_pkg::t_cfg i_cfg,
    mbps_byte_if.sink      i_req,
    mbps_res_if.source     o_res
);
    import mbps_pkg::*;

    logic                    r_in_valid;
    t_byte                   r_in_byte;
    logic                    r_in_last;
    t_byte [PATTERN_MAX-1:0] r_win;
    t_byte [PATTERN_MAX-1:0] n_win;
    logic [CNT_W-1:0]        r_seen;
    logic [CNT_W-1:0]        n_seen;
    logic                    r_matched;
    logic                    n_matched;
    logic                    r_out_valid;
    logic                    r_out_found;
    logic [ADDR_W-1:0]       r_out_addr;
    logic                    out_free;
    logic                    adv;
    logic                    hit;
    logic [CNT_W-1:0]        offset;

    assign out_free    = !r_out_valid || o_res.ready;
    assign adv         = r_in_valid && (!r_in_last || out_free);
    assign i_req.ready = !r_in_valid || adv;

    always_comb begin
        n_win    = r_win;
        n_seen   = r_seen;
        n_matched = r_matched;
        hit      = 1'b1;
        if (!r_matched) begin
            n_win[0] = r_in_byte;
            for (int k = 1; k < PATTERN_MAX; k++) begin
                n_win[k] = r_win[k-1];
            end
            if (r_seen != {CNT_W{1'b1}}) begin
                n_seen = r_seen + CNT_W'(1);
            end
            for (int p = 0; p < PATTERN_MAX; p++) begin
                if (i_cfg.care[p] && n_win[p] != i_cfg.pat[p]) begin
                    hit = 1'b0;
                end
            end
            n_matched = (i_cfg.len != '0) && (n_seen >= CNT_W'(i_cfg.len)) && hit;
        end
    end

    assign offset = n_seen - CNT_W'(i_cfg.len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_seen      <= '0;
            r_matched   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (adv) begin
                if (r_in_last) begin
                    r_seen    <= '0;
                    r_matched <= 1'b0;
                end else begin
                    r_seen    <= n_seen;
                    r_matched <= n_matched;
                end
            end
            if (adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte <= i_req.data_byte;
            r_in_last <= i_req.region_end;
        end
        if (adv) begin
            r_win <= n_win;
        end
        if (adv && r_in_last) begin
            r_out_found <= n_matched;
            r_out_addr  <= n_matched ? i_cfg.base + ADDR_W'(offset) : '0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.found         = r_out_found;
    assign o_res.match_address = r_out_addr;

endmodule

`default_nettype wire

// ----- rtl/masked_byte_pattern_search.sv -----
// Top level of the masked byte pattern search block.
// Depends on mbps_pkg, mbps_if, mbps_cfg and mbps_core.
`default_nettype none

// Scans a region one byte per request (region_end on the last byte) for a
// pattern of up to PATTERN_MAX bytes with a per-byte care mask; one result per
// region gives found and region_base plus the offset of the first match.
// Throughput is one byte per cycle unless a region's last byte waits while the
// result register is full; that byte passes the request, then the result register.
// The cycle is set by the masked compare of the byte window to the aligned pattern.
// Writes pass the cfg and aligned-pattern registers. No clearing pass after reset.
module masked_byte_pattern_search (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mbps_byte_if.sink                        i_req,
    mbps_res_if.source                       o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mbps_pkg::APB_AW-1:0] paddr,
    input  wire logic [mbps_pkg::APB_DW-1:0] pwdata,
    output logic      [mbps_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import mbps_pkg::*;

    t_cfg cfg;

    mbps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbps_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
